[src/sha_pkg.sv]
`default_nettype none
package sha_pkg;

	typedef enum logic {
		CMD_ABSORB = 1'b0,
		CMD_FINISH = 1'b1
	} cmd_code_t;

	localparam int unsigned NUM_ROUNDS = 64;
	localparam int unsigned NUM_WORDS  = 8;
	localparam int unsigned BLK_WORDS  = 16;

	localparam logic [2:0] LAST_IDX  = 3'd7;
	localparam logic [5:0] LAST_RND  = 6'd63;
	localparam logic [5:0] FULL_FILL = 6'd63;
	// 0x80 plus the 8-byte length no longer fits once fill reaches 56
	localparam logic [5:0] LEN_POS   = 6'd56;
	localparam logic [7:0] PAD_BYTE  = 8'h80;
	localparam logic [63:0] BLK_BITS = 64'd512;

	localparam logic [31:0] INIT_H [0:7] = '{
		32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
		32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
	};

	localparam logic [31:0] ROUND_K [0:63] = '{
		32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
		32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
		32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
		32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
		32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
		32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
		32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
		32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
		32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
		32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
		32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
		32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
		32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
		32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
		32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
		32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
	};

	typedef struct packed {
		logic       absorb_we;
		logic       finish_acc;
		logic       load_vars;
		logic       pad;
		logic       len_only;
		logic       round_en;
		logic       add_hash;
		logic       restart;
		logic [5:0] round_idx;
		logic [2:0] out_idx;
	} dp_cmd_t;

	typedef struct packed {
		logic fill_full;
		logic two_blocks;
	} dp_sts_t;

endpackage
`default_nettype wire

[src/sha_dp.sv]
`default_nettype none
module sha_dp (
	input  wire                logic clk,
	input  wire                logic arst_n,
	input  wire sha_pkg::dp_cmd_t dp_cmd,
	output sha_pkg::dp_sts_t   dp_sts,
	input  wire                logic [7:0] data_byte,
	output logic               [31:0] digest_word
);
	import sha_pkg::*;

	logic [31:0] hash_q [0:7];
	logic [31:0] v_q [0:7];
	logic [31:0] w_q [0:15];
	logic [31:0] pad_w [0:15];
	logic [5:0]  fill_q;
	logic [63:0] bits_q;

	logic [31:0] t1, t2, bs0, bs1, chs, mj, sg0, sg1, w_new;

	function automatic logic [31:0] rotr(input logic [31:0] x, input int unsigned n);
		return (x >> n) | (x << (32 - n));
	endfunction

	assign dp_sts.fill_full  = (fill_q == FULL_FILL);
	assign dp_sts.two_blocks = (fill_q >= LEN_POS);

	// one compression round on a..h, schedule word taken from the head of the window
	always_comb begin
		bs1 = rotr(v_q[4], 6) ^ rotr(v_q[4], 11) ^ rotr(v_q[4], 25);
		chs = (v_q[4] & v_q[5]) ^ (~v_q[4] & v_q[6]);
		t1  = v_q[7] + bs1 + chs + ROUND_K[dp_cmd.round_idx] + w_q[0];
		bs0 = rotr(v_q[0], 2) ^ rotr(v_q[0], 13) ^ rotr(v_q[0], 22);
		mj  = (v_q[0] & v_q[1]) ^ (v_q[0] & v_q[2]) ^ (v_q[1] & v_q[2]);
		t2  = bs0 + mj;
		sg0 = rotr(w_q[1], 7) ^ rotr(w_q[1], 18) ^ (w_q[1] >> 3);
		sg1 = rotr(w_q[14], 17) ^ rotr(w_q[14], 19) ^ (w_q[14] >> 10);
		w_new = w_q[0] + sg0 + w_q[9] + sg1;
	end

	// padded block: keep bytes below fill, 0x80 at fill, zeros above, length in words 14-15 if room
	always_comb begin
		for (int i = 0; i < BLK_WORDS; i++) begin
			for (int b = 0; b < 4; b++) begin
				if (6'(4 * i + b) < fill_q)
					pad_w[i][31 - 8 * b -: 8] = w_q[i][31 - 8 * b -: 8];
				else if (6'(4 * i + b) == fill_q)
					pad_w[i][31 - 8 * b -: 8] = PAD_BYTE;
				else
					pad_w[i][31 - 8 * b -: 8] = 8'h00;
			end
		end
		if (!dp_sts.two_blocks) begin
			pad_w[14] = bits_q[63:32];
			pad_w[15] = bits_q[31:0];
		end
	end

	always_ff @(posedge clk) begin
		if (dp_cmd.absorb_we) begin
			w_q[fill_q[5:2]][{~fill_q[1:0], 3'b000} +: 8] <= data_byte;
		end else if (dp_cmd.pad) begin
			w_q <= pad_w;
		end else if (dp_cmd.len_only) begin
			for (int i = 0; i < 14; i++)
				w_q[i] <= '0;
			w_q[14] <= bits_q[63:32];
			w_q[15] <= bits_q[31:0];
		end else if (dp_cmd.round_en) begin
			for (int i = 0; i < 15; i++)
				w_q[i] <= w_q[i + 1];
			w_q[15] <= w_new;
		end

		if (dp_cmd.load_vars) begin
			v_q <= hash_q;
		end else if (dp_cmd.round_en) begin
			v_q[7] <= v_q[6];
			v_q[6] <= v_q[5];
			v_q[5] <= v_q[4];
			v_q[4] <= v_q[3] + t1;
			v_q[3] <= v_q[2];
			v_q[2] <= v_q[1];
			v_q[1] <= v_q[0];
			v_q[0] <= t1 + t2;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hash_q <= INIT_H;
			fill_q <= '0;
			bits_q <= '0;
		end else if (dp_cmd.restart) begin
			hash_q <= INIT_H;
			fill_q <= '0;
			bits_q <= '0;
		end else begin
			if (dp_cmd.absorb_we) begin
				fill_q <= fill_q + 6'd1;
				if (dp_sts.fill_full)
					bits_q <= bits_q + BLK_BITS;
			end
			if (dp_cmd.finish_acc)
				bits_q <= bits_q + {55'd0, fill_q, 3'b000};
			if (dp_cmd.add_hash) begin
				for (int i = 0; i < NUM_WORDS; i++)
					hash_q[i] <= hash_q[i] + v_q[i];
			end
		end
	end

	assign digest_word = hash_q[dp_cmd.out_idx];

endmodule
`default_nettype wire

[src/sha_ctrl.sv]
`default_nettype none
module sha_ctrl (
	input  wire              logic clk,
	input  wire              logic arst_n,
	input  wire              logic in_valid,
	output logic             in_ready,
	input  wire              logic cmd,
	output logic             out_valid,
	input  wire              logic out_ready,
	output sha_pkg::dp_cmd_t dp_cmd,
	input  wire sha_pkg::dp_sts_t dp_sts
);
	import sha_pkg::*;

	typedef enum logic [2:0] {
		S_IDLE,
		S_PAD,
		S_LEN,
		S_ROUND,
		S_FINAL,
		S_OUT
	} state_t;

	state_t     state_q;
	logic [5:0] round_q;
	logic [2:0] out_idx_q;
	logic       finish_q;
	logic       second_q;
	logic       in_fire;
	logic       absorb;
	logic       last_out;

	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = (state_q == S_OUT);
	assign in_fire   = in_valid && in_ready;
	assign absorb    = in_fire && (cmd == CMD_ABSORB);
	assign last_out  = out_valid && out_ready && (out_idx_q == LAST_IDX);

	always_comb begin
		dp_cmd            = '0;
		dp_cmd.absorb_we  = absorb;
		dp_cmd.finish_acc = in_fire && (cmd == CMD_FINISH);
		dp_cmd.load_vars  = (absorb && dp_sts.fill_full) || (state_q == S_PAD)
			|| (state_q == S_LEN);
		dp_cmd.pad        = (state_q == S_PAD);
		dp_cmd.len_only   = (state_q == S_LEN);
		dp_cmd.round_en   = (state_q == S_ROUND);
		dp_cmd.add_hash   = (state_q == S_FINAL);
		dp_cmd.restart    = last_out;
		dp_cmd.round_idx  = round_q;
		dp_cmd.out_idx    = out_idx_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			round_q   <= '0;
			out_idx_q <= '0;
			finish_q  <= 1'b0;
			second_q  <= 1'b0;
		end else begin
			case (state_q)
				S_IDLE: begin
					round_q <= '0;
					if (in_fire) begin
						if (cmd == CMD_FINISH) begin
							finish_q <= 1'b1;
							second_q <= dp_sts.two_blocks;
							state_q  <= S_PAD;
						end else if (dp_sts.fill_full) begin
							finish_q <= 1'b0;
							state_q  <= S_ROUND;
						end
					end
				end
				S_PAD, S_LEN: begin
					round_q <= '0;
					state_q <= S_ROUND;
				end
				S_ROUND: begin
					round_q <= round_q + 6'd1;
					if (round_q == LAST_RND)
						state_q <= S_FINAL;
				end
				S_FINAL: begin
					if (!finish_q) begin
						state_q <= S_IDLE;
					end else if (second_q) begin
						second_q <= 1'b0;
						state_q  <= S_LEN;
					end else begin
						out_idx_q <= '0;
						state_q   <= S_OUT;
					end
				end
				S_OUT: begin
					if (out_ready) begin
						out_idx_q <= out_idx_q + 3'd1;
						if (out_idx_q == LAST_IDX) begin
							finish_q <= 1'b0;
							state_q  <= S_IDLE;
						end
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule
`default_nettype wire

[src/sha256_stream_hash_top.sv]
// Absorb item: stores one byte; the byte that completes a block also starts the
// 64 rounds, one round per cycle on a shared round unit, and then the hash update.
// Finish item: pad, 64 rounds, update, and again for a length block if the padding
// spills into a second block; then 8 digest words at one per accepted cycle.
// One item at a time; in_ready is low while a block compresses or the digest drains.
// arst_n (async, active low) loads the initial hash and clears fill and bit count.
`default_nettype none
module sha256_stream_hash_top (
	input  wire  logic        clk,
	input  wire  logic        arst_n,
	input  wire  logic        in_valid,
	output logic              in_ready,
	input  wire  logic        cmd,
	input  wire  logic [7:0]  data_byte,
	output logic              out_valid,
	input  wire  logic        out_ready,
	output logic [31:0]       digest_word,
	output logic [2:0]        word_index,
	output logic              last_word
);
	import sha_pkg::*;

	dp_cmd_t dp_cmd;
	dp_sts_t dp_sts;

	sha_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.cmd       (cmd),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.dp_cmd    (dp_cmd),
		.dp_sts    (dp_sts)
	);

	sha_dp u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.dp_cmd      (dp_cmd),
		.dp_sts      (dp_sts),
		.data_byte   (data_byte),
		.digest_word (digest_word)
	);

	assign word_index = dp_cmd.out_idx;
	assign last_word  = (dp_cmd.out_idx == LAST_IDX);

endmodule
`default_nettype wire

[src/sha_chk.sv]
`default_nettype none
module sha_chk (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        in_valid,
	input wire logic        in_ready,
	input wire logic        cmd,
	input wire logic        out_valid,
	input wire logic        out_ready,
	input wire logic [31:0] digest_word,
	input wire logic [2:0]  word_index,
	input wire logic        last_word
);
	import sha_pkg::*;

	// input side stays closed while the digest drains
	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		!(in_ready && out_valid))
		else $error("input taken while digest pending");

	a_finish_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready && cmd == CMD_FINISH) |=> !in_ready && !out_valid)
		else $error("finish item did not start compression");

	a_word_order: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_ready && !last_word) |=>
			(out_valid && word_index == 3'($past(word_index) + 3'd1)))
		else $error("digest words out of order");

	a_last_ends: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_ready && last_word) |=> !out_valid && in_ready)
		else $error("output continues past last word");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |=>
			(out_valid && $stable(digest_word) && $stable(word_index)))
		else $error("stalled digest word changed");

endmodule

bind sha256_stream_hash_top sha_chk u_sha_chk (
	.clk         (clk),
	.arst_n      (arst_n),
	.in_valid    (in_valid),
	.in_ready    (in_ready),
	.cmd         (cmd),
	.out_valid   (out_valid),
	.out_ready   (out_ready),
	.digest_word (digest_word),
	.word_index  (word_index),
	.last_word   (last_word)
);
`default_nettype wire
